// File: src/rcfp_pkg.sv
// shared constants, command and status types for the rc serial frame parser
// no dependencies
package rcfp_pkg;

    localparam int CHANNELS = 14;

    // channel counter width and byte position width inside the channel block
    localparam int CHAN_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int POS_W  = CHAN_W + 1;

    localparam logic [POS_W-1:0]  LAST_POS  = POS_W'(2 * CHANNELS - 1);
    localparam logic [CHAN_W-1:0] LAST_CHAN = CHAN_W'(CHANNELS - 1);

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_HEADER  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COMMAND = 2'd1;

    localparam logic [7:0]  HDR_RESET  = 8'd32;
    localparam logic [7:0]  CMD_RESET  = 8'd64;
    localparam logic [15:0] CKSUM_BASE = 16'hFFFF;

    // controller to datapath
    typedef struct packed {
        logic clear;      // back to hunt: position and sum to zero
        logic sum_load;   // sum takes the header byte
        logic sum_add;    // sum accumulates the byte
        logic store;      // write channel byte, advance position
        logic ck_lo;      // capture low checksum byte
        logic chan_rst;   // restart channel counter
        logic rd_issue;   // read both byte stores at channel counter
        logic load_chan;  // load output registers from read data
        logic chan_next;  // advance channel counter
        logic load_err;   // load output registers with error result
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic hdr_match;
        logic cmd_match;
        logic data_done;
        logic ck_ok;
        logic out_last;
    } stat_t;

endpackage

// File: src/rcfp_ram.sv
// generic single write port ram with registered read
// no dependencies
module rcfp_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: src/rcfp_datapath.sv
// datapath: config registers, byte position, checksum sum, byte stores, result registers
// depends on rcfp_pkg and rcfp_ram
module rcfp_datapath
    import rcfp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_data,
    input  logic [7:0]           data_byte,
    input  cmd_t                 cmd,
    output stat_t                stat,
    output logic                 status,
    output logic [3:0]           channel_index,
    output logic [15:0]          channel_value,
    output logic                 last
);

    logic [7:0]        hdr_reg, hdr_next;
    logic [7:0]        cmdb_reg, cmdb_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [15:0]       sum_reg, sum_next;
    logic [7:0]        cklo_reg;
    logic [CHAN_W-1:0] chan_reg, chan_next;
    logic              status_reg;
    logic [3:0]        index_reg;
    logic [15:0]       value_reg;
    logic              last_reg;
    logic [7:0]        lo_rdata, hi_rdata;

    always_comb
    begin
        hdr_next  = hdr_reg;
        cmdb_next = cmdb_reg;
        if (cfg_wr && cfg_index == REG_HEADER)
        begin
            hdr_next = cfg_data;
        end
        if (cfg_wr && cfg_index == REG_COMMAND)
        begin
            cmdb_next = cfg_data;
        end
    end

    always_comb
    begin
        pos_next = pos_reg;
        sum_next = sum_reg;
        if (cmd.store)
        begin
            pos_next = pos_reg + POS_W'(1);
        end
        if (cmd.sum_load)
        begin
            sum_next = {8'd0, data_byte};
        end
        else if (cmd.sum_add)
        begin
            sum_next = sum_reg + {8'd0, data_byte};
        end
        if (cmd.clear)
        begin
            pos_next = '0;
            sum_next = '0;
        end
    end

    always_comb
    begin
        chan_next = chan_reg;
        if (cmd.chan_rst)
        begin
            chan_next = '0;
        end
        else if (cmd.chan_next)
        begin
            chan_next = chan_reg + CHAN_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_reg  <= HDR_RESET;
            cmdb_reg <= CMD_RESET;
            pos_reg  <= '0;
            sum_reg  <= '0;
            chan_reg <= '0;
        end
        else
        begin
            hdr_reg  <= hdr_next;
            cmdb_reg <= cmdb_next;
            pos_reg  <= pos_next;
            sum_reg  <= sum_next;
            chan_reg <= chan_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (cmd.ck_lo)
        begin
            cklo_reg <= data_byte;
        end
        if (cmd.load_err)
        begin
            status_reg <= 1'b1;
            index_reg  <= 4'd0;
            value_reg  <= 16'd0;
            last_reg   <= 1'b1;
        end
        else if (cmd.load_chan)
        begin
            status_reg <= 1'b0;
            index_reg  <= 4'(chan_reg);
            value_reg  <= {hi_rdata, lo_rdata};
            last_reg   <= (chan_reg == LAST_CHAN);
        end
    end

    // even positions hold low bytes, odd positions high bytes
    rcfp_ram #(.WIDTH(8), .DEPTH(CHANNELS)) u_lo_ram (
        .clk     (clk),
        .wr_en   (cmd.store && !pos_reg[0]),
        .wr_addr (pos_reg[POS_W-1:1]),
        .wr_data (data_byte),
        .rd_en   (cmd.rd_issue),
        .rd_addr (chan_reg),
        .rd_data (lo_rdata)
    );

    rcfp_ram #(.WIDTH(8), .DEPTH(CHANNELS)) u_hi_ram (
        .clk     (clk),
        .wr_en   (cmd.store && pos_reg[0]),
        .wr_addr (pos_reg[POS_W-1:1]),
        .wr_data (data_byte),
        .rd_en   (cmd.rd_issue),
        .rd_addr (chan_reg),
        .rd_data (hi_rdata)
    );

    assign stat.hdr_match = (data_byte == hdr_reg);
    assign stat.cmd_match = (data_byte == cmdb_reg);
    assign stat.data_done = (pos_reg == LAST_POS);
    assign stat.ck_ok     = ((CKSUM_BASE - sum_reg) == {data_byte, cklo_reg});
    assign stat.out_last  = last_reg;

    assign status        = status_reg;
    assign channel_index = index_reg;
    assign channel_value = value_reg;
    assign last          = last_reg;

endmodule

// File: src/rcfp_ctrl.sv
// controller: frame phase state machine and result sequencing
// depends on rcfp_pkg
module rcfp_ctrl
    import rcfp_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_stall,
    output logic  out_valid,
    input  logic  out_stall,
    input  stat_t stat,
    output cmd_t  cmd
);

    typedef enum logic [7:0] {
        ST_HUNT  = 8'b00000001,
        ST_CMD   = 8'b00000010,
        ST_DATA  = 8'b00000100,
        ST_CK_LO = 8'b00001000,
        ST_CK_HI = 8'b00010000,
        ST_READ  = 8'b00100000,
        ST_OUT   = 8'b01000000,
        ST_LOAD  = 8'b10000000
    } state_t;

    state_t state_reg, state_next;
    logic   in_fire;

    assign in_stall  = (state_reg == ST_READ) || (state_reg == ST_LOAD) ||
                       (state_reg == ST_OUT);
    assign in_fire   = in_valid && !in_stall;
    assign out_valid = (state_reg == ST_OUT);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_HUNT:
            begin
                if (in_fire && stat.hdr_match)
                begin
                    cmd.sum_load = 1'b1;
                    state_next   = ST_CMD;
                end
            end
            ST_CMD:
            begin
                if (in_fire)
                begin
                    if (stat.cmd_match)
                    begin
                        cmd.sum_add = 1'b1;
                        state_next  = ST_DATA;
                    end
                    else
                    begin
                        cmd.clear  = 1'b1;
                        state_next = ST_HUNT;
                    end
                end
            end
            ST_DATA:
            begin
                if (in_fire)
                begin
                    cmd.store   = 1'b1;
                    cmd.sum_add = 1'b1;
                    if (stat.data_done)
                    begin
                        state_next = ST_CK_LO;
                    end
                end
            end
            ST_CK_LO:
            begin
                if (in_fire)
                begin
                    cmd.ck_lo  = 1'b1;
                    state_next = ST_CK_HI;
                end
            end
            ST_CK_HI:
            begin
                if (in_fire)
                begin
                    cmd.clear = 1'b1;
                    if (stat.ck_ok)
                    begin
                        cmd.chan_rst = 1'b1;
                        state_next   = ST_READ;
                    end
                    else
                    begin
                        cmd.load_err = 1'b1;
                        state_next   = ST_OUT;
                    end
                end
            end
            ST_READ:
            begin
                cmd.rd_issue = 1'b1;
                state_next   = ST_LOAD;
            end
            ST_LOAD:
            begin
                cmd.load_chan = 1'b1;
                state_next    = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_stall)
                begin
                    if (stat.out_last)
                    begin
                        state_next = ST_HUNT;
                    end
                    else
                    begin
                        cmd.chan_next = 1'b1;
                        state_next    = ST_READ;
                    end
                end
            end
            default:
            begin
                cmd.clear  = 1'b1;
                state_next = ST_HUNT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_HUNT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // last result taken returns to the hunt
    a_last_to_hunt: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT && !out_stall && stat.out_last) |=> (state_reg == ST_HUNT))
        else $error("last result did not return to hunt");

    // every read is followed by a result load
    a_read_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |=> (state_reg == ST_LOAD))
        else $error("read not followed by load");

    // the closing checksum byte always yields results
    a_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CK_HI && in_fire) |=> (state_reg == ST_READ || state_reg == ST_OUT))
        else $error("frame end without results");

    // no byte is taken while results are pending
    a_no_take: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOAD) |=> (state_reg == ST_OUT && in_stall))
        else $error("input open during result burst");

endmodule

// File: src/rc_serial_frame_parser.sv
// rc serial frame parser top level: joins controller and datapath, config write port
// depends on rcfp_pkg, rcfp_ctrl, rcfp_datapath, rcfp_ram
// timing: a good frame's first result is valid once the READ and LOAD states have passed after
//   the last checksum byte is taken (an error result the next cycle), each further one after READ and LOAD again
// throughput: one byte per cycle inside a frame; input held off for the whole result burst
// reset: phase to hunt, position and sum cleared, header 32 and command 64; byte stores not reset
module rc_serial_frame_parser
    import rcfp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // received byte stream
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [7:0]           data_byte,
    // result stream
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 status,
    output logic [3:0]           channel_index,
    output logic [15:0]          channel_value,
    output logic                 last,
    // configuration writes
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_data
);

    cmd_t  cmd;
    stat_t stat;

    // config registers take a transfer in any cycle
    assign cfg_ready = 1'b1;

    // controller: phase tracking, input flow control, result sequencing
    rcfp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    // datapath: header compare, running sum, channel byte stores, result registers
    rcfp_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr        (cfg_valid && cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .data_byte     (data_byte),
        .cmd           (cmd),
        .stat          (stat),
        .status        (status),
        .channel_index (channel_index),
        .channel_value (channel_value),
        .last          (last)
    );

endmodule

// File: bench/testbench.sv
// self-checking bench for rc_serial_frame_parser: byte stream in, channel results out
// holds its own frame predictor and scoreboard; depends on rcfp_pkg and the rtl only
module testbench;
    import rcfp_pkg::*;

    // frame geometry: two header bytes, channel block, two checksum bytes
    localparam int FRAME_LEN    = 2 * CHANNELS + 4;
    localparam int PHASE_ITEMS  = 60;
    localparam int DRAIN_CYCLES = 16;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int MAX_PRINTED  = 40;

    // result status codes
    localparam logic ST_GOOD      = 1'b0;
    localparam logic ST_CKSUM_ERR = 1'b1;

    // register indexes past the end of the register file, writes must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    typedef struct packed {
        logic        status;
        logic [3:0]  index;
        logic [15:0] value;
        logic        last;
    } chan_result_t;

    typedef logic [7:0] byte_q_t [$];

    // predictor of the parser plus the queue of results still owed by the block
    class frame_scoreboard;
        typedef enum logic [1:0] {HUNT, AWAIT_CMD, COLLECT} parse_phase_t;

        parse_phase_t phase;
        int unsigned  pos;
        logic [7:0]   chan_bytes [2*CHANNELS];
        logic [15:0]  frame_sum;
        logic [7:0]   cks_low;
        logic [7:0]   hdr_byte;
        logic [7:0]   cmd_byte;
        chan_result_t expected_q [$];
        int unsigned  errors;

        function new();
            hdr_byte = HDR_RESET;
            cmd_byte = CMD_RESET;
            cks_low  = 8'd0;
            errors   = 0;
            restart();
        endfunction

        function void restart();
            phase     = HUNT;
            pos       = 0;
            frame_sum = 16'd0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
            if (idx == REG_HEADER)
                hdr_byte = val;
            else if (idx == REG_COMMAND)
                cmd_byte = val;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // one accepted byte: advance the parse and queue whatever it yields
        function void note_byte(logic [7:0] b);
            logic [15:0] got;
            case (phase)
                HUNT: begin
                    if (b == hdr_byte) begin
                        frame_sum = 16'(b);
                        pos       = 1;
                        phase     = AWAIT_CMD;
                    end
                end
                AWAIT_CMD: begin
                    if (b == cmd_byte) begin
                        frame_sum += 16'(b);
                        pos        = 2;
                        phase      = COLLECT;
                    end else begin
                        restart();
                    end
                end
                default: begin
                    if (pos < FRAME_LEN - 2) begin
                        chan_bytes[pos-2] = b;
                        frame_sum += 16'(b);
                        pos++;
                    end else if (pos == FRAME_LEN - 2) begin
                        cks_low = b;
                        pos++;
                    end else begin
                        got = {b, cks_low};
                        if (got == CKSUM_BASE - frame_sum) begin
                            for (int k = 0; k < CHANNELS; k++)
                                expected_q.insert(expected_q.size(),
                                    '{status: ST_GOOD, index: 4'(k),
                                    value: {chan_bytes[2*k+1], chan_bytes[2*k]},
                                    last: 1'(k == CHANNELS - 1)});
                        end else begin
                            expected_q.insert(expected_q.size(),
                                '{status: ST_CKSUM_ERR, index: 4'd0,
                                value: 16'd0, last: 1'b1});
                        end
                        restart();
                    end
                end
            endcase
        endfunction

        task report(string what);
            if (errors < MAX_PRINTED)
                $display("mismatch: %s", what);
            errors++;
        endtask

        task check_result(logic st, logic [3:0] idx, logic [15:0] val, logic lst);
            chan_result_t want;
            if (expected_q.size() == 0) begin
                report($sformatf("unexpected result status %0b ch %0d value %h last %0b",
                                 st, idx, val, lst));
                return;
            end
            want = expected_q.pop_front();
            if (st !== want.status)
                report($sformatf("status %0b, want %0b", st, want.status));
            if (idx !== want.index)
                report($sformatf("channel_index %0d, want %0d", idx, want.index));
            if (val !== want.value)
                report($sformatf("ch %0d channel_value %h, want %h", want.index, val,
                                 want.value));
            if (lst !== want.last)
                report($sformatf("ch %0d last %0b, want %0b", want.index, lst, want.last));
        endtask
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic [7:0]           data_byte;
    logic                 out_valid;
    logic                 out_stall;
    logic                 status;
    logic [3:0]           channel_index;
    logic [15:0]          channel_value;
    logic                 last;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [7:0]           cfg_data;

    frame_scoreboard sb = new();

    // idle rates in percent, changed per phase
    int unsigned src_idle_pct  = 0;
    int unsigned sink_stall_pct = 0;
    int unsigned cycle_count;

    // header and command the block holds right now, used to build frames
    logic [7:0] cur_hdr = HDR_RESET;
    logic [7:0] cur_cmd = CMD_RESET;

    // tail of a frame cut by a phase boundary, sent after the register writes
    byte_q_t carry_q;

    rc_serial_frame_parser dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .data_byte     (data_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .channel_index (channel_index),
        .channel_value (channel_value),
        .last          (last),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog: any hang or missing result ends here
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("rc_serial_frame_parser regression: fail");
        $finish;
    end

    // result side: random stall driven at the falling edge
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            out_stall <= ($urandom_range(99) < sink_stall_pct);
        end
    end

    // a result transfer happens at a rising edge with valid high and stall low
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(status, channel_index, channel_value, last);
    end

    // one byte transfer; valid stays up across back-to-back bytes
    task automatic send_byte(input logic [7:0] b);
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_byte(b);
    endtask

    task automatic send_bytes(input byte_q_t q);
        foreach (q[i])
            send_byte(q[i]);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.set_reg(idx, val);
        if (idx == REG_HEADER)
            cur_hdr = val;
        else if (idx == REG_COMMAND)
            cur_cmd = val;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // stop the byte stream and let every owed result come out
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        // bytes that yield nothing may still be in flight
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // whole frame for the current header and command
    // extremes: fixed pattern of all-zero, all-one and half-set channel values
    function automatic void build_frame(input bit corrupt, input bit extremes,
                                        output byte_q_t q);
        logic [15:0] sum;
        logic [15:0] cks;
        logic [15:0] v;
        q = {};
        q.insert(q.size(), cur_hdr);
        q.insert(q.size(), cur_cmd);
        sum = 16'(cur_hdr) + 16'(cur_cmd);
        for (int k = 0; k < CHANNELS; k++)
        begin
            if (extremes)
            begin
                case (k % 4)
                    0:       v = 16'h0000;
                    1:       v = 16'hFFFF;
                    2:       v = 16'h00FF;
                    default: v = 16'hFF00;
                endcase
            end
            else
            begin
                case ($urandom_range(7))
                    0:       v = 16'h0000;
                    1:       v = 16'hFFFF;
                    default: v = 16'($urandom);
                endcase
            end
            q.insert(q.size(), v[7:0]);
            q.insert(q.size(), v[15:8]);
            sum = sum + 16'(v[7:0]) + 16'(v[15:8]);
        end
        cks = CKSUM_BASE - sum;
        if (corrupt)
            cks = cks ^ 16'($urandom_range(1, 65535));
        q.insert(q.size(), cks[7:0]);
        q.insert(q.size(), cks[15:8]);
    endfunction

    function automatic logic [7:0] byte_other_than(input logic [7:0] avoid);
        logic [7:0] b;
        b = 8'($urandom);
        while (b == avoid)
            b = 8'($urandom);
        return b;
    endfunction

    // random traffic for one phase: mostly clean frames, some bad checksums,
    // broken headers and line noise between them
    task automatic random_traffic(input int unsigned budget);
        byte_q_t     q;
        int unsigned sent;
        int unsigned pick;
        sent = 0;
        while (sent < budget)
        begin
            pick = $urandom_range(99);
            q = {};
            if (pick < 70)
                build_frame(1'b0, 1'b0, q);
            else if (pick < 82)
                build_frame(1'b1, 1'b0, q);
            else if (pick < 90)
            begin
                // header followed by a wrong command, sometimes the header again
                q.insert(q.size(), cur_hdr);
                if ($urandom_range(1) && cur_hdr != cur_cmd)
                    q.insert(q.size(), cur_hdr);
                else
                    q.insert(q.size(), byte_other_than(cur_cmd));
            end
            else
            begin
                // noise while hunting, kept off the header value
                repeat ($urandom_range(1, 4))
                    q.insert(q.size(), byte_other_than(cur_hdr));
            end
            send_bytes(q);
            if (pick < 90)
                sent += q.size();
        end
    endtask

    // send part of a good frame now and keep the rest for the next phase,
    // so register writes land in the middle of a frame
    task automatic split_frame();
        byte_q_t     q;
        int unsigned cut;
        build_frame(1'b0, 1'b0, q);
        cut = $urandom_range(1, FRAME_LEN - 1);
        carry_q = {};
        for (int i = 0; i < FRAME_LEN; i++)
        begin
            if (i < cut)
                send_byte(q[i]);
            else
                carry_q.insert(carry_q.size(), q[i]);
        end
    endtask

    initial
    begin
        byte_q_t q;
        logic [7:0] same;

        // every input known from time zero
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        data_byte = 8'd0;
        cfg_valid = 1'b0;
        cfg_index = REG_HEADER;
        cfg_data  = 8'd0;
        carry_q   = {};

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int ph = 0; ph < 4; ph++)
        begin
            // idle mix: none, sender gaps, receiver stalls, both
            case (ph)
                0:       begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1:       begin src_idle_pct = 84; sink_stall_pct = 0;  end
                2:       begin src_idle_pct = 0;  sink_stall_pct = 84; end
                default: begin src_idle_pct = 31; sink_stall_pct = 31; end
            endcase

            // register settings per phase; the first phase runs on reset values
            case (ph)
                1:
                begin
                    write_reg(REG_HEADER, 8'h00);
                    write_reg(REG_COMMAND, 8'hFF);
                    write_reg(REG_SPARE_A, 8'($urandom));
                end
                2:
                begin
                    write_reg(REG_HEADER, 8'hFF);
                    write_reg(REG_COMMAND, 8'h00);
                    write_reg(REG_SPARE_B, 8'($urandom));
                end
                3:
                begin
                    // header equal to command: a repeated header is taken as command
                    same = 8'($urandom_range(1, 254));
                    write_reg(REG_HEADER, same);
                    write_reg(REG_COMMAND, same);
                end
                default: ;
            endcase

            // finish the frame cut at the last boundary under the new settings
            send_bytes(carry_q);
            carry_q = {};

            if (ph == 0)
            begin
                // noise at both ends of the byte range
                send_byte(8'h00);
                send_byte(8'hFF);
                // wrong command, then the header as command: dropped, not re-tested
                send_byte(cur_hdr);
                send_byte(8'h00);
                send_byte(cur_hdr);
                send_byte(cur_hdr);
                send_byte(cur_cmd);
                // good frame with extreme channel values, then a bad checksum
                build_frame(1'b0, 1'b1, q);
                send_bytes(q);
                build_frame(1'b1, 1'b1, q);
                send_bytes(q);
            end

            random_traffic(PHASE_ITEMS);
            if (ph < 3)
                split_frame();
            drain();
        end

        if (sb.errors == 0)
            $display("rc_serial_frame_parser regression: pass");
        else
            $display("rc_serial_frame_parser regression: fail");
        $finish;
    end

endmodule
